// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// expression never holds
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition");

`endif

// ===== hw/rtl/rbba_pkg.sv =====
// ---------------------------------------------------------------------------
// rbba_pkg
// shared widths, codes and types of the row band box average block
// ---------------------------------------------------------------------------
package rbba_pkg;

   localparam int PIX_W      = 8;
   localparam int KSIZE_W    = 5;
   localparam int CROW_W     = 10;
   localparam int IMG_W      = 11;
   localparam int COLSUM_W   = 12;
   localparam int WSUM_W     = 16;
   localparam int AVG_W      = 16;
   localparam int IDX_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // divider: dividend is the window sum scaled by 256, divisor is k*k
   localparam int FRAC_W        = 8;
   localparam int DVD_W         = WSUM_W + FRAC_W;
   localparam int DVS_W         = 2 * KSIZE_W;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = DVD_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RESET  = KSIZE_W'(3);
   localparam logic [CROW_W-1:0]  CENTER_ROW_RESET   = CROW_W'(1);
   localparam logic [IMG_W-1:0]   IMAGE_WIDTH_RESET  = IMG_W'(1024);
   localparam logic [IMG_W-1:0]   IMAGE_HEIGHT_RESET = IMG_W'(1024);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_SIZE,
      CSR_CENTER_ROW,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [KSIZE_W-1:0] kernel_size;
      logic [CROW_W-1:0]  center_row;
      logic [IMG_W-1:0]   image_width;
      logic [IMG_W-1:0]   image_height;
   } cfg_type;

   typedef enum logic {
      CMD_ERROR,
      CMD_PIXEL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               clr_win;
      logic               in_band;
      logic               first_row;
      logic               last_row;
      logic               sub;
      logic               emit;
      logic               last_win;
      logic [PIX_W-1:0]   pixel;
      logic [KSIZE_W-1:0] kernel_size;
      logic [IDX_W-1:0]   window_index;
   } cmd_type;

   typedef struct packed {
      logic [AVG_W-1:0] window_average;
      logic [IDX_W-1:0] window_index;
      logic             last_window;
      logic             status;
   } res_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_EXEC,
      B_DIV,
      B_PUSH
   } back_state_type;

endpackage

// ===== hw/rtl/rbba_ram.sv =====
// ---------------------------------------------------------------------------
// rbba_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module rbba_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/rbba_fifo.sv =====
// ---------------------------------------------------------------------------
// rbba_fifo
// small register queue with full and empty flags
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbba_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(DEPTH))

endmodule

// ===== hw/rtl/rbba_div.sv =====
// ---------------------------------------------------------------------------
// rbba_div
// restoring divider, several quotient bits per cycle
// ---------------------------------------------------------------------------
module rbba_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rbba_pkg::DVD_W-1:0] dividend,
   input  logic [rbba_pkg::DVS_W-1:0] divisor,
   output logic                       done,
   output logic [rbba_pkg::DVD_W-1:0] quotient
);

   import rbba_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W:0]       rem_t;
   logic [DVD_W-1:0]     quo_t;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_t   = '0;
      quo_t   = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_t = {1'b0, rem_ff};
         for (int i = 0; i < DIV_STEP_BITS; i++) begin
            rem_t = {rem_t[DVS_W-1:0], quo_t[DVD_W-1]};
            quo_t = {quo_t[DVD_W-2:0], 1'b0};
            if (rem_t >= {1'b0, dvs_ff}) begin
               rem_t    = rem_t - {1'b0, dvs_ff};
               quo_t[0] = 1'b1;
            end
         end
         rem_in = rem_t[DVS_W-1:0];
         quo_in = quo_t;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/rbba_front.sv =====
// ---------------------------------------------------------------------------
// rbba_front
// pixel intake: setup check, raster position and band classification
// ---------------------------------------------------------------------------
module rbba_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rbba_pkg::cfg_type               cfg,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [rbba_pkg::PIX_W-1:0]      req_pixel,
   input  logic                            req_frame_start,
   input  logic                            cq_full,
   output logic                            cq_push,
   output rbba_pkg::cmd_type               cq_cmd,
   output logic [$clog2(MAX_WIDTH)-1:0]    cq_col
);

   import rbba_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int PW = (CW > RW) ? CW : RW;
   localparam int AW = ((PW > IMG_W) ? PW : IMG_W) + 1;

   logic [CW-1:0] col_ff, col_in, cur_col;
   logic [RW-1:0] row_ff, row_in, cur_row;
   logic          invalid_ff, invalid_in;

   logic [AW-1:0] k_x, khalf_x, w_x, h_x, cr_x, start_x, end_x;
   logic [AW-1:0] r_x, c_x, c1_x, c2_x, r1_x, idx_x;
   logic          setup_ok, accept, process, in_band, last_row;

   always_comb begin
      k_x     = AW'(cfg.kernel_size);
      khalf_x = k_x >> 1;
      w_x     = AW'(cfg.image_width);
      h_x     = AW'(cfg.image_height);
      cr_x    = AW'(cfg.center_row);
      start_x = cr_x - khalf_x;
      end_x   = start_x + k_x;

      setup_ok = (k_x != '0) && (k_x <= AW'(MAX_KERNEL))
              && (w_x != '0) && (w_x <= AW'(MAX_WIDTH))
              && (h_x != '0) && (h_x <= AW'(MAX_HEIGHT))
              && (k_x <= w_x) && (k_x <= h_x)
              && (cr_x >= khalf_x) && (end_x <= h_x);

      // a frame start restarts counting at the top left corner
      cur_col = req_frame_start ? '0 : col_ff;
      cur_row = req_frame_start ? '0 : row_ff;
      r_x     = AW'(cur_row);
      c_x     = AW'(cur_col);
      c1_x    = c_x + AW'(1);
      c2_x    = c_x + AW'(2);
      r1_x    = r_x + AW'(1);
      idx_x   = c1_x - k_x;

      accept   = req_push && !cq_full;
      process  = setup_ok && (req_frame_start || !invalid_ff);
      in_band  = (r_x >= start_x) && (r_x < end_x);
      last_row = (r_x == end_x - AW'(1));

      cq_cmd.kind         = (req_frame_start && !setup_ok) ? CMD_ERROR : CMD_PIXEL;
      cq_cmd.clr_win      = req_frame_start || (last_row && (c_x == '0));
      cq_cmd.in_band      = in_band;
      cq_cmd.first_row    = (r_x == start_x);
      cq_cmd.last_row     = last_row;
      cq_cmd.sub          = (c_x >= k_x);
      cq_cmd.emit         = in_band && last_row && (c1_x >= k_x) && (c2_x <= w_x);
      cq_cmd.last_win     = (c2_x == w_x);
      cq_cmd.pixel        = req_pixel;
      cq_cmd.kernel_size  = cfg.kernel_size;
      cq_cmd.window_index = idx_x[IDX_W-1:0];
      cq_col              = cur_col;

      cq_push = accept && (req_frame_start || (process && in_band));

      col_in     = col_ff;
      row_in     = row_ff;
      invalid_in = invalid_ff;
      if (accept) begin
         if (req_frame_start) begin
            invalid_in = !setup_ok;
            col_in     = '0;
            row_in     = '0;
         end
         if (process) begin
            if (c1_x >= w_x) begin
               col_in = '0;
               row_in = (r1_x >= h_x) ? '0 : r1_x[RW-1:0];
            end else begin
               col_in = c1_x[CW-1:0];
               row_in = cur_row;
            end
         end
      end
   end

   assign req_full = cq_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         invalid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         invalid_ff <= invalid_in;
      end
   end

endmodule

// ===== hw/rtl/rbba_back.sv =====
// ---------------------------------------------------------------------------
// rbba_back
// command execution: column sum update, sliding window and mean
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbba_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cq_empty,
   output logic                         cq_pop,
   input  rbba_pkg::cmd_type            cq_cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0] cq_col,
   input  logic                         res_full,
   output logic                         res_push,
   output rbba_pkg::res_type            res
);

   import rbba_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = CW + KSIZE_W;

   back_state_type      state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [WSUM_W-1:0]   win_ff, win_in;
   res_type             res_ff, res_in;

   logic [XW-1:0]       back_addr;
   logic [CW-1:0]       raddr_b;
   logic [COLSUM_W-1:0] rd_a, rd_b, new_sum;
   logic [WSUM_W-1:0]   base, win_add, win_upd;
   logic [DVS_W-1:0]    ksq;
   logic                ram_we, div_start, div_done;
   logic [DVD_W-1:0]    div_quotient;

   // column c-k, already updated earlier on this row
   assign back_addr = XW'(cq_col) - XW'(cq_cmd.kernel_size);
   assign raddr_b   = back_addr[CW-1:0];

   rbba_ram #(.WIDTH(COLSUM_W), .DEPTH(MAX_WIDTH)) u_ram_cur (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata (new_sum),
      .raddr (cq_col),
      .rdata (rd_a)
   );

   rbba_ram #(.WIDTH(COLSUM_W), .DEPTH(MAX_WIDTH)) u_ram_back (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata (new_sum),
      .raddr (raddr_b),
      .rdata (rd_b)
   );

   rbba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({win_upd, FRAC_W'(0)}),
      .divisor  (ksq),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      new_sum = cur_ff.first_row ? COLSUM_W'(cur_ff.pixel)
                                 : rd_a + COLSUM_W'(cur_ff.pixel);
      base    = cur_ff.clr_win ? '0 : win_ff;
      win_add = base + WSUM_W'(new_sum);
      win_upd = cur_ff.sub ? win_add - WSUM_W'(rd_b) : win_add;
      ksq     = DVS_W'(cur_ff.kernel_size) * DVS_W'(cur_ff.kernel_size);

      state_in  = state_ff;
      cur_in    = cur_ff;
      col_in    = col_ff;
      win_in    = win_ff;
      res_in    = res_ff;
      cq_pop    = 1'b0;
      res_push  = 1'b0;
      ram_we    = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (!cq_empty) begin
               cq_pop   = 1'b1;
               cur_in   = cq_cmd;
               col_in   = cq_col;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            if (cur_ff.kind == CMD_ERROR) begin
               win_in                = '0;
               res_in.window_average = '0;
               res_in.window_index   = '0;
               res_in.last_window    = 1'b0;
               res_in.status         = 1'b1;
               state_in              = B_PUSH;
            end else begin
               ram_we = cur_ff.in_band;
               win_in = (cur_ff.in_band && cur_ff.last_row) ? win_upd : base;
               if (cur_ff.emit) begin
                  div_start           = 1'b1;
                  res_in.window_index = cur_ff.window_index;
                  res_in.last_window  = cur_ff.last_win;
                  res_in.status       = 1'b0;
                  state_in            = B_DIV;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_DIV: begin
            if (div_done) begin
               res_in.window_average = div_quotient[AVG_W-1:0];
               state_in              = B_PUSH;
            end
         end
         B_PUSH: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      col_ff <= col_in;
      res_ff <= res_in;
   end

   assign res = res_ff;

   `ASSERT_IMPLIES(a_div_done_in_div, clock, reset, div_done, state_ff == B_DIV)
   `ASSERT_IMPLIES(a_err_no_write, clock, reset, (state_ff == B_EXEC) && (cur_ff.kind == CMD_ERROR), !ram_we)
   `ASSERT_NEXT(a_exec_after_pop, clock, reset, cq_pop, state_ff == B_EXEC)

endmodule

// ===== hw/rtl/row_band_box_average.sv =====
// ---------------------------------------------------------------------------
// row_band_box_average
// box filter mean over one band of image rows, 8.8 fixed point results
// ---------------------------------------------------------------------------
// Grey pixels enter in raster order through a queue-style port (req_push /
// req_full); window means leave through a queue-style port (rsp_empty /
// rsp_pop). The front takes one pixel per clock while its command queue has
// room: pixels outside the averaged band are counted and dropped there in
// the same cycle. Pixels inside the band, and every frame start, become
// commands for the back, which takes one at a time: a column memory read,
// then the column sum and window update. A pixel that completes a window
// also waits in the back while the mean divides by kernel_size squared in
// a divider that yields 4 quotient bits per cycle, then for the push into
// the result queue. A frame that fails the setup check, e.g. a band that
// does not fit, gives one result with status 1 at its frame start and
// nothing else. The csr port is always ready; write it between frames,
// once all results are taken. Column memory needs no clearing after reset.
// ---------------------------------------------------------------------------
module row_band_box_average #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel requests
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [rbba_pkg::PIX_W-1:0]        req_pixel,
   input  logic                              req_frame_start,
   // window results
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [rbba_pkg::AVG_W-1:0]        rsp_window_average,
   output logic [rbba_pkg::IDX_W-1:0]        rsp_window_index,
   output logic                              rsp_last_window,
   output logic                              rsp_status,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbba_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import rbba_pkg::*;

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int CMD_W     = $bits(cmd_type) + CW;
   localparam int RES_W     = $bits(res_type);
   localparam int CQ_DEPTH  = 4;
   localparam int RQ_DEPTH  = 2;

   cfg_type       cfg_ff, cfg_in;

   // front to back command queue
   logic          cq_push, cq_full, cq_pop, cq_empty;
   cmd_type       front_cmd, back_cmd;
   logic [CW-1:0] front_col, back_col;
   logic [CMD_W-1:0] cq_dout;

   // back to port result queue
   logic          res_push, res_full;
   res_type       back_res, out_res;
   logic [RES_W-1:0] rq_dout;

   // -----------------------------------------------------------------------
   // configuration registers, written by index
   // -----------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KERNEL_SIZE:  cfg_in.kernel_size  = csr_wdata[KSIZE_W-1:0];
            CSR_CENTER_ROW:   cfg_in.center_row   = csr_wdata[CROW_W-1:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[IMG_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[IMG_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_size  <= KERNEL_SIZE_RESET;
         cfg_ff.center_row   <= CENTER_ROW_RESET;
         cfg_ff.image_width  <= IMAGE_WIDTH_RESET;
         cfg_ff.image_height <= IMAGE_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // -----------------------------------------------------------------------
   // front: setup check, raster position, band classification
   // -----------------------------------------------------------------------
   rbba_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .cq_full         (cq_full),
      .cq_push         (cq_push),
      .cq_cmd          (front_cmd),
      .cq_col          (front_col)
   );

   // command queue decouples intake from the multi-cycle back
   rbba_fifo #(.WIDTH(CMD_W), .DEPTH(CQ_DEPTH)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cq_push),
      .din   ({front_col, front_cmd}),
      .full  (cq_full),
      .pop   (cq_pop),
      .dout  (cq_dout),
      .empty (cq_empty)
   );

   assign back_cmd = cmd_type'(cq_dout[$bits(cmd_type)-1:0]);
   assign back_col = cq_dout[CMD_W-1:$bits(cmd_type)];

   // -----------------------------------------------------------------------
   // back: column memory, sliding window sum, divider
   // -----------------------------------------------------------------------
   rbba_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cq_empty (cq_empty),
      .cq_pop   (cq_pop),
      .cq_cmd   (back_cmd),
      .cq_col   (back_col),
      .res_full (res_full),
      .res_push (res_push),
      .res      (back_res)
   );

   // result queue lets the back finish while the consumer stalls
   rbba_fifo #(.WIDTH(RES_W), .DEPTH(RQ_DEPTH)) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (back_res),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (rq_dout),
      .empty (rsp_empty)
   );

   assign out_res            = res_type'(rq_dout);
   assign rsp_window_average = out_res.window_average;
   assign rsp_window_index   = out_res.window_index;
   assign rsp_last_window    = out_res.last_window;
   assign rsp_status         = out_res.status;

endmodule
